[rtl/mpb_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and defaults of the max pooling backward block
package mpb_pkg;

  // default store geometry
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_MAX_DEPTH  = 16;
  localparam int DEF_MAX_WINDOW = 8;

  // field widths fixed by the interface
  localparam int REQ_W   = 2;
  localparam int CHAN_W  = 4;
  localparam int POS_W   = 6;
  localparam int DATA_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  // internal map coordinate width, holds any configured size
  localparam int MAP_W   = 7;
  // width used for compares against the store limits
  localparam int LIM_W   = 11;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPLY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_DEPTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT  = 3'd6;

  // configuration reset values
  localparam logic [3:0] RST_WINDOW_SIZE = 4'd2;
  localparam logic [3:0] RST_STEP_SIZE   = 4'd2;
  localparam logic [6:0] RST_IN_WIDTH    = 7'd28;
  localparam logic [6:0] RST_IN_HEIGHT   = 7'd28;
  localparam logic [4:0] RST_MAP_DEPTH   = 5'd1;
  localparam logic [6:0] RST_OUT_WIDTH   = 7'd14;
  localparam logic [6:0] RST_OUT_HEIGHT  = 7'd14;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // sequencer states
  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_CHECK   = 8'b0000_0100,
    ST_SCAN    = 8'b0000_1000,
    ST_DRAIN   = 8'b0001_0000,
    ST_GRAD_RD = 8'b0010_0000,
    ST_GRAD_WR = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } state_t;

endpackage

[rtl/mpb_ram.sv]
`timescale 1ns / 1ps
// simple dual port synchronous ram with a registered read port
module mpb_ram #(
  parameter int ADDR_W = 16,
  parameter int WORD_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [2**ADDR_W];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/max_pool_backward.sv]
`timescale 1ns / 1ps
// top level of the max pooling backward block
//
// usage: one request transaction enters on the in_ channel (valid/ready) and
// gives at most one result transaction on the out_ channel (valid/ready).
// load writes an activation, apply adds an output gradient at the first
// maximum of its pooling window, read returns a gradient and clears it.
// request type 3 is dropped without a result. cfg_ writes are taken at any
// time but are only meant to change while the block is idle.
// timing: one request at a time; the sequencer holds in_ready low until the
// request is finished. load writes in the check state; read adds a gradient
// read and write; apply first sweeps the single read port of the activation
// ram once per window element, then drains and does the gradient read and
// write. the result is registered as the sequencer leaves its done state.
// reset: the gradient ram is swept to zero, one word per cycle, across all
// MAX_DEPTH*MAX_HEIGHT*MAX_WIDTH words rounded up to powers of two
// (65536 words with the defaults); in_ready stays low meanwhile.
// stall: a finished result sits in the output register; the next request is
// still accepted and runs until its own result is ready to be handed over.
module max_pool_backward
  import mpb_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic [CHAN_W-1:0]        in_chan,
  input  logic [POS_W-1:0]         in_pos_row,
  input  logic [POS_W-1:0]         in_pos_col,
  input  logic signed [DATA_W-1:0] in_data_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_status,
  output logic signed [DATA_W-1:0] out_grad_value,
  output logic [POS_W-1:0]         out_arg_row,
  output logic [POS_W-1:0]         out_arg_col,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  // address = {channel, row, column}, each field sized by its store limit
  localparam int A_CH_W  = (MAX_DEPTH  > 1) ? $clog2(MAX_DEPTH)  : 1;
  localparam int A_ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int A_COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int ADDR_W  = A_CH_W + A_ROW_W + A_COL_W;

  localparam logic [LIM_W-1:0] LIM_WIDTH  = LIM_W'(MAX_WIDTH);
  localparam logic [LIM_W-1:0] LIM_HEIGHT = LIM_W'(MAX_HEIGHT);
  localparam logic [LIM_W-1:0] LIM_DEPTH  = LIM_W'(MAX_DEPTH);
  localparam logic [LIM_W-1:0] LIM_WINDOW = LIM_W'(MAX_WINDOW);

  function automatic logic [ADDR_W-1:0] cell_addr(
    input logic [CHAN_W-1:0] c,
    input logic [MAP_W-1:0]  r,
    input logic [MAP_W-1:0]  x
  );
    return {A_CH_W'(c), A_ROW_W'(r), A_COL_W'(x)};
  endfunction

  // signed add clamped to the 32 bit range
  function automatic logic [DATA_W-1:0] sat_add(
    input logic [DATA_W-1:0] a,
    input logic [DATA_W-1:0] b
  );
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return s[DATA_W-1:0];
  endfunction

  // configuration registers
  logic [3:0] window_size_r;
  logic [3:0] step_size_r;
  logic [6:0] in_width_r;
  logic [6:0] in_height_r;
  logic [4:0] map_depth_r;
  logic [6:0] out_width_r;
  logic [6:0] out_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= RST_WINDOW_SIZE;
      step_size_r   <= RST_STEP_SIZE;
      in_width_r    <= RST_IN_WIDTH;
      in_height_r   <= RST_IN_HEIGHT;
      map_depth_r   <= RST_MAP_DEPTH;
      out_width_r   <= RST_OUT_WIDTH;
      out_height_r  <= RST_OUT_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_SIZE: window_size_r <= cfg_data[3:0];
        CFG_STEP_SIZE:   step_size_r   <= cfg_data[3:0];
        CFG_IN_WIDTH:    in_width_r    <= cfg_data;
        CFG_IN_HEIGHT:   in_height_r   <= cfg_data;
        CFG_MAP_DEPTH:   map_depth_r   <= cfg_data[4:0];
        CFG_OUT_WIDTH:   out_width_r   <= cfg_data;
        CFG_OUT_HEIGHT:  out_height_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state and control
  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic [3:0]         scan_y_r, scan_x_r;
  logic               out_free;

  // captured request
  logic [REQ_W-1:0]   req_r;
  logic [CHAN_W-1:0]  chan_r;
  logic [POS_W-1:0]   row_r, col_r;
  logic [DATA_W-1:0]  data_r;

  // window origin, valid once the apply check has passed
  logic [MAP_W-1:0]   org_row_r, org_col_r;

  // running maximum of the window
  logic               rd_v_r;
  logic [MAP_W-1:0]   rd_row_r, rd_col_r;
  logic               have_best_r;
  logic [DATA_W-1:0]  best_val_r;
  logic [MAP_W-1:0]   best_row_r, best_col_r;

  // result waiting for the output register
  logic               res_status_r;
  logic [DATA_W-1:0]  res_grad_r;
  logic [POS_W-1:0]   res_row_r, res_col_r;

  // output register
  logic               out_valid_r;
  logic               out_status_r;
  logic [DATA_W-1:0]  out_grad_r;
  logic [POS_W-1:0]   out_row_r, out_col_r;

  // ram ports
  logic               act_we, act_re;
  logic [ADDR_W-1:0]  act_waddr, act_raddr;
  logic [DATA_W-1:0]  act_rdata;
  logic               grd_we, grd_re;
  logic [ADDR_W-1:0]  grd_waddr, grd_raddr;
  logic [DATA_W-1:0]  grd_wdata, grd_rdata;

  // range checks on the captured request
  logic [MAP_W-1:0]   row_m, col_m;
  logic               chan_ok, in_pos_ok, apply_ok;
  logic [9:0]         org_row, org_col;
  logic [LIM_W-1:0]   end_row, end_col;
  logic [MAP_W-1:0]   scan_row, scan_col;
  logic               scan_last_x, scan_last_y;
  logic [3:0]         win_last;

  assign row_m   = {1'b0, row_r};
  assign col_m   = {1'b0, col_r};
  assign chan_ok = ({1'b0, chan_r} < map_depth_r) && (LIM_W'(chan_r) < LIM_DEPTH);
  assign in_pos_ok = chan_ok &&
                     (row_m < in_height_r) && (LIM_W'(row_r) < LIM_HEIGHT) &&
                     (col_m < in_width_r)  && (LIM_W'(col_r) < LIM_WIDTH);

  assign org_row = 10'(step_size_r) * 10'(row_r);
  assign org_col = 10'(step_size_r) * 10'(col_r);
  assign end_row = LIM_W'(org_row) + LIM_W'(window_size_r);
  assign end_col = LIM_W'(org_col) + LIM_W'(window_size_r);

  assign apply_ok = chan_ok &&
                    (row_m < out_height_r) && (col_m < out_width_r) &&
                    (window_size_r != 4'd0) && (LIM_W'(window_size_r) <= LIM_WINDOW) &&
                    (step_size_r != 4'd0) &&
                    (end_row <= LIM_W'(in_height_r)) && (end_row <= LIM_HEIGHT) &&
                    (end_col <= LIM_W'(in_width_r))  && (end_col <= LIM_WIDTH);

  // window walk in raster order
  assign win_last    = window_size_r - 4'd1;
  assign scan_last_x = (scan_x_r == win_last);
  assign scan_last_y = (scan_y_r == win_last);
  assign scan_row    = org_row_r + MAP_W'(scan_y_r);
  assign scan_col    = org_col_r + MAP_W'(scan_x_r);

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == {ADDR_W{1'b1}}) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        case (req_r)
          REQ_LOAD:  state_nxt = ST_DONE;
          REQ_READ:  state_nxt = in_pos_ok ? ST_GRAD_RD : ST_DONE;
          REQ_APPLY: state_nxt = apply_ok ? ST_SCAN : ST_DONE;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (scan_last_x && scan_last_y) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:   state_nxt = ST_GRAD_RD;
      ST_GRAD_RD: state_nxt = ST_GRAD_WR;
      ST_GRAD_WR: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
    end
  end

  // request capture and window counters
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r  <= in_req_type;
      chan_r <= in_chan;
      row_r  <= in_pos_row;
      col_r  <= in_pos_col;
      data_r <= in_data_value;
    end
    if (state_r == ST_CHECK) begin
      // origin fits in map width whenever the window check passes
      org_row_r <= org_row[MAP_W-1:0];
      org_col_r <= org_col[MAP_W-1:0];
      scan_y_r  <= 4'd0;
      scan_x_r  <= 4'd0;
    end else if (state_r == ST_SCAN) begin
      if (scan_last_x) begin
        scan_x_r <= 4'd0;
        scan_y_r <= scan_y_r + 4'd1;
      end else begin
        scan_x_r <= scan_x_r + 4'd1;
      end
    end
  end

  // running maximum; a later equal value does not win
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= (state_r == ST_SCAN);
    end
    rd_row_r <= scan_row;
    rd_col_r <= scan_col;
    if (state_r == ST_CHECK) begin
      have_best_r <= 1'b0;
      best_row_r  <= row_m;
      best_col_r  <= col_m;
    end else if (rd_v_r) begin
      if (!have_best_r || ($signed(act_rdata) > $signed(best_val_r))) begin
        have_best_r <= 1'b1;
        best_val_r  <= act_rdata;
        best_row_r  <= rd_row_r;
        best_col_r  <= rd_col_r;
      end
    end
  end

  // result assembly
  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK) begin
      res_grad_r <= '0;
      res_row_r  <= '0;
      res_col_r  <= '0;
      case (req_r)
        REQ_LOAD:  res_status_r <= in_pos_ok ? STATUS_OK : STATUS_ERR;
        REQ_READ:  res_status_r <= in_pos_ok ? STATUS_OK : STATUS_ERR;
        REQ_APPLY: res_status_r <= apply_ok ? STATUS_OK : STATUS_ERR;
        default:   res_status_r <= STATUS_ERR;
      endcase
    end else if (state_r == ST_GRAD_WR) begin
      if (req_r == REQ_APPLY) begin
        res_row_r <= best_row_r[POS_W-1:0];
        res_col_r <= best_col_r[POS_W-1:0];
      end else begin
        res_grad_r <= grd_rdata;
      end
    end
  end

  // output register, refilled from the finished request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_status_r <= res_status_r;
      out_grad_r   <= res_grad_r;
      out_row_r    <= res_row_r;
      out_col_r    <= res_col_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_grad_value = out_grad_r;
  assign out_arg_row    = out_row_r;
  assign out_arg_col    = out_col_r;

  // activation ram: load writes, window scan reads
  assign act_we    = (state_r == ST_CHECK) && (req_r == REQ_LOAD) && in_pos_ok;
  assign act_waddr = cell_addr(chan_r, row_m, col_m);
  assign act_re    = (state_r == ST_SCAN);
  assign act_raddr = cell_addr(chan_r, scan_row, scan_col);

  // gradient ram: clearing sweep, then read-modify-write at the chosen cell
  assign grd_re    = (state_r == ST_GRAD_RD);
  assign grd_raddr = cell_addr(chan_r, best_row_r, best_col_r);

  always_comb begin
    grd_we    = 1'b0;
    grd_waddr = cell_addr(chan_r, best_row_r, best_col_r);
    grd_wdata = '0;
    if (state_r == ST_CLEAR) begin
      grd_we    = 1'b1;
      grd_waddr = clr_addr_r;
    end else if (state_r == ST_GRAD_WR) begin
      grd_we    = 1'b1;
      grd_wdata = (req_r == REQ_APPLY) ? sat_add(grd_rdata, data_r) : '0;
    end
  end

  mpb_ram #(
    .ADDR_W (ADDR_W),
    .WORD_W (DATA_W)
  ) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (data_r),
    .re    (act_re),
    .raddr (act_raddr),
    .rdata (act_rdata)
  );

  mpb_ram #(
    .ADDR_W (ADDR_W),
    .WORD_W (DATA_W)
  ) u_grad_ram (
    .clk   (clk),
    .we    (grd_we),
    .waddr (grd_waddr),
    .wdata (grd_wdata),
    .re    (grd_re),
    .raddr (grd_raddr),
    .rdata (grd_rdata)
  );

endmodule
